// ===== rtl/selection_sort_engine_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the sort engine core RTL.
// ---------------------------------------------------------------------------
`ifndef SELECTION_SORT_ENGINE_CORE_MACROS_SVH
`define SELECTION_SORT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define SSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sort engine assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define SSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sort engine assertion failed");

`endif

// ===== rtl/sse_pkg.sv =====
// ---------------------------------------------------------------------------
// sse_pkg
// Widths, sizes and shared types of the selection sort engine.
// ---------------------------------------------------------------------------
package sse_pkg;

	localparam int DEPTH = 16;
	localparam int VAL_W = 31;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TMR_W = $clog2(DEPTH);

	// Empty cells hold the largest value; it sorts to the far end of the chain.
	localparam logic [VAL_W-1:0] SENTINEL = {VAL_W{1'b1}};

	typedef logic [VAL_W-1:0] val_t;

	typedef enum logic [2:0] {
		ST_LOAD   = 3'b001,
		ST_SETTLE = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

endpackage

// ===== rtl/sse_cell.sv =====
// ---------------------------------------------------------------------------
// sse_cell
// One sorting cell: keeps the smaller of its value and the incoming one and
// hands the larger to its right neighbor; shifts left while results drain.
// ---------------------------------------------------------------------------
module sse_cell
	import sse_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  val_t in_val,
	input  logic shift,
	input  val_t right_val,
	output val_t own_val,
	output val_t pass_val
);

	val_t own_q;
	val_t pass_q;
	logic in_less;

	assign in_less = in_val < own_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q  <= SENTINEL;
			pass_q <= SENTINEL;
		end else if (shift) begin
			own_q  <= right_val;
			pass_q <= SENTINEL;
		end else begin
			own_q  <= in_less ? in_val : own_q;
			pass_q <= in_less ? own_q : in_val;
		end
	end

	assign own_val  = own_q;
	assign pass_val = pass_q;

endmodule

// ===== rtl/selection_sort_engine_core.sv =====
// ---------------------------------------------------------------------------
// selection_sort_engine_core
// Collects non-negative values and emits them in ascending order.
// ---------------------------------------------------------------------------
// Input requests carry one signed sample_value; they are taken while
// in_stall is low. A non-negative value joins the list, a negative value
// ends it and is dropped, and the DEPTH-th value ends the list at once.
// A negative value on an empty list is taken and has no effect.
// During loading each value enters the first cell of a row of DEPTH cells,
// and the larger of each comparison ripples one cell right per cycle.
// After the list ends, in_stall rises while that ripple settles, then one
// result per cycle leaves the first cell as the row shifts left, as long as
// out_stall lets it; last_flag marks the final result.
// Results wait in an output register; when out_stall is high the row holds
// and the held request stays unchanged. The next list may start loading
// while the final result is still waiting in that register.
// Reset fills every cell with the largest value and returns to loading.
// ---------------------------------------------------------------------------
module selection_sort_engine_core
	import sse_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  sample_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [VAL_W-1:0]    sorted_value,
	output logic                last_flag
);

	`include "selection_sort_engine_core_macros.svh"

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [TMR_W-1:0] timer_q;
	logic             out_valid_q;
	val_t             sorted_q;
	logic             last_q;

	val_t cell_own [DEPTH];
	val_t cell_pass [DEPTH];
	val_t cell_in [DEPTH];
	val_t cell_right [DEPTH];

	logic in_accept;
	logic is_negative;
	logic emit_fire;

	assign in_stall    = (state_q != ST_LOAD);
	assign in_accept   = in_valid && !in_stall;
	assign is_negative = sample_value[31];
	assign emit_fire   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// Outside of loading the first cell sees only the largest value.
	assign cell_in[0] = (in_accept && !is_negative) ? val_t'(sample_value[VAL_W-1:0]) : SENTINEL;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			if (g > 0) begin : g_link
				assign cell_in[g] = cell_pass[g-1];
			end
			if (g < DEPTH - 1) begin : g_right
				assign cell_right[g] = cell_own[g+1];
			end else begin : g_end
				assign cell_right[g] = SENTINEL;
			end
			sse_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_val    (cell_in[g]),
				.shift     (emit_fire),
				.right_val (cell_right[g]),
				.own_val   (cell_own[g]),
				.pass_val  (cell_pass[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			timer_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_accept) begin
						if (is_negative) begin
							if (count_q != '0) begin
								state_q <= ST_SETTLE;
								timer_q <= TMR_W'(DEPTH - 1);
							end
						end else begin
							count_q <= count_q + 1'b1;
							if (count_q == CNT_W'(DEPTH - 1)) begin
								state_q <= ST_SETTLE;
								timer_q <= TMR_W'(DEPTH - 1);
							end
						end
					end
				end
				ST_SETTLE: begin
					timer_q <= timer_q - 1'b1;
					if (timer_q == '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						count_q <= count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			sorted_q <= cell_own[0];
			last_q   <= (count_q == CNT_W'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_q;
	assign last_flag    = last_q;

	`SSE_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CNT_W'(DEPTH))
	`SSE_ASSERT_NOW(a_settle_nonempty, state_q != ST_LOAD, count_q != '0)
	`SSE_ASSERT_NOW(a_head_sorted, state_q == ST_EMIT, cell_own[0] <= cell_own[1])
	`SSE_ASSERT_NEXT(a_last_returns, emit_fire && count_q == CNT_W'(1),
		state_q == ST_LOAD && last_flag && out_valid)

endmodule
